// ----- src/pst_pkg.sv -----
// pst_pkg: shared widths, codes and handshake structs for the servo torque block.
// No dependencies; used by pst_booth_mul, pst_integrator and pid_servo_torque.
package pst_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN = 2'd2;

  localparam int GAIN_W  = 24;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = DATA_W + 1;
  localparam int INTEG_W = 48;

  // serial multiplier geometry
  localparam int MCAND_W     = INTEG_W;        // widest multiplicand: the integral
  localparam int MPLIER_W    = DATA_W + 2;     // dt zero-extended to an even signed width
  localparam int ACC_W       = MCAND_W + 3;
  localparam int PROD_W      = ACC_W + MPLIER_W;
  localparam int DIGIT_CNT_W = 5;
  localparam logic [DIGIT_CNT_W-1:0] DT_DIGITS   = 5'd17;
  localparam logic [DIGIT_CNT_W-1:0] GAIN_DIGITS = 5'd12;

  // increment of the integral: floor(err*dt / 2^8)
  localparam int INC_W = 58;

  // torque accumulator, Q.40
  localparam int SUM_W = 76;

  localparam logic [DATA_W-1:0] TORQUE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] TORQUE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                   start;
    logic [MCAND_W-1:0]     mcand;   // two's complement
    logic [MPLIER_W-1:0]    mplier;  // two's complement
    logic [DIGIT_CNT_W-1:0] digits;  // radix-4 digits to retire
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

// ----- src/pst_booth_mul.sv -----
// pst_booth_mul: radix-4 Booth serial multiplier, one digit per cycle.
// Depends on pst_pkg (widths, mul_req_t, mul_rsp_t).
module pst_booth_mul (
  input  logic              clk,
  input  logic              rst,
  input  pst_pkg::mul_req_t req,
  output pst_pkg::mul_rsp_t rsp
);

  logic [pst_pkg::ACC_W-1:0]       acc;
  logic [pst_pkg::MPLIER_W-1:0]    mq;
  logic                            qm1;
  logic [pst_pkg::MCAND_W-1:0]     mcand_r;
  logic [pst_pkg::DIGIT_CNT_W-1:0] cnt;
  logic                            busy;
  logic                            done;

  logic                      neg;
  logic                      one;
  logic                      two;
  logic [pst_pkg::ACC_W-1:0] mc_ext;
  logic [pst_pkg::ACC_W-1:0] mag;
  logic [pst_pkg::ACC_W-1:0] sum;

  always_comb begin
    neg    = mq[1];
    one    = mq[0] ^ qm1;
    two    = (mq[1] & ~mq[0] & ~qm1) | (~mq[1] & mq[0] & qm1);
    mc_ext = {{(pst_pkg::ACC_W - pst_pkg::MCAND_W){mcand_r[pst_pkg::MCAND_W-1]}}, mcand_r};
    if (one) begin
      mag = mc_ext;
    end else if (two) begin
      mag = {mc_ext[pst_pkg::ACC_W-2:0], 1'b0};
    end else begin
      mag = '0;
    end
    sum = neg ? (acc - mag) : (acc + mag);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == pst_pkg::DIGIT_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.digits;
      end else if (busy) begin
        cnt <= cnt - pst_pkg::DIGIT_CNT_W'(1);
        if (cnt == pst_pkg::DIGIT_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: {acc, mq} shifts right two bits per digit
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= '0;
      mq      <= req.mplier;
      qm1     <= 1'b0;
      mcand_r <= req.mcand;
    end else if (busy) begin
      acc <= {{2{sum[pst_pkg::ACC_W-1]}}, sum[pst_pkg::ACC_W-1:2]};
      mq  <= {sum[1:0], mq[pst_pkg::MPLIER_W-1:2]};
      qm1 <= mq[1];
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {acc, mq};

endmodule

// ----- src/pst_integrator.sv -----
// pst_integrator: saturating Q24.24 error integral.
// Depends on pst_pkg (INTEG_W, INC_W).
module pst_integrator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        update,
  input  logic [pst_pkg::INC_W-1:0]   inc,
  output logic [pst_pkg::INTEG_W-1:0] integral
);

  localparam int SW = pst_pkg::INC_W + 1;

  logic [pst_pkg::INTEG_W-1:0] error_integral;
  logic [SW-1:0]               sum;
  logic                        fits;
  logic [pst_pkg::INTEG_W-1:0] error_integral_next;

  always_comb begin
    sum = {{(SW - pst_pkg::INTEG_W){error_integral[pst_pkg::INTEG_W-1]}}, error_integral}
        + {inc[pst_pkg::INC_W-1], inc};
    fits = (&sum[SW-1:pst_pkg::INTEG_W-1]) | ~(|sum[SW-1:pst_pkg::INTEG_W-1]);
    if (fits) begin
      error_integral_next = sum[pst_pkg::INTEG_W-1:0];
    end else if (sum[SW-1]) begin
      error_integral_next = {1'b1, {(pst_pkg::INTEG_W-1){1'b0}}};
    end else begin
      error_integral_next = {1'b0, {(pst_pkg::INTEG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
    end else if (update) begin
      error_integral <= error_integral_next;
    end
  end

  assign integral = error_integral;

endmodule

// ----- src/pid_servo_torque.sv -----
// pid_servo_torque: PID position servo, derivative taken from measured velocity.
// Transactions: one at a time; in_stall stays high from acceptance until the result
//   is registered, while 17 + 3*12 radix-4 digits run on the shared multiplier and
//   the sum is negated and saturated; S_HOLD waits while the output channel stalls.
// Reset (rst, synchronous): gains, previous time, integral and control cleared.
// Depends on pst_pkg, pst_booth_mul, pst_integrator.
module pid_servo_torque (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [pst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pst_pkg::GAIN_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            target_position,
  input  logic signed [31:0]            measured_position,
  input  logic signed [31:0]            measured_velocity,
  input  logic [31:0]                   sample_time,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            drive_torque
);

  // Sequencer: one multiply per state, the multiplier is the only arithmetic
  // that works serially. Order: err*dt, p*err, d*vel, i*integral.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL_T = 8'b0000_0010,
    S_MUL_P = 8'b0000_0100,
    S_MUL_D = 8'b0000_1000,
    S_MUL_I = 8'b0001_0000,
    S_NEG   = 8'b0010_0000,
    S_SAT   = 8'b0100_0000,
    S_HOLD  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [pst_pkg::GAIN_W-1:0]  p_gain;
  logic [pst_pkg::GAIN_W-1:0]  d_gain;
  logic [pst_pkg::GAIN_W-1:0]  i_gain;
  logic [pst_pkg::DATA_W-1:0]  previous_time;
  logic [pst_pkg::ERR_W-1:0]   err_r;
  logic [pst_pkg::DATA_W-1:0]  vel_r;
  logic [pst_pkg::DATA_W-1:0]  dt_r;
  logic [pst_pkg::SUM_W-1:0]   psum;   // p*err*256 + d*vel*256 + i*integral, Q.40
  logic [pst_pkg::SUM_W-1:0]   nsum;   // -psum
  logic                        mul_go;

  pst_pkg::mul_req_t           mreq;
  pst_pkg::mul_rsp_t           mrsp;
  logic [pst_pkg::INTEG_W-1:0] integral;
  logic                        integ_update;
  logic                        in_take;
  logic                        out_free;

  // gain product: low Q bits still hold unused sign copies of the multiplier
  localparam int GP_LSB = pst_pkg::MPLIER_W - pst_pkg::GAIN_W;
  logic [pst_pkg::PROD_W-1:GP_LSB] gprod;
  logic [pst_pkg::SUM_W-1:0]       gprod_x256;
  logic [pst_pkg::SUM_W-1:0]       gprod_ext;
  logic                            sat_fits;
  logic [pst_pkg::DATA_W-1:0]      torque_sat;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // config writes; index three is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= '0;
      d_gain <= '0;
      i_gain <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pst_pkg::REG_P_GAIN: p_gain <= cfg_data;
        pst_pkg::REG_D_GAIN: d_gain <= cfg_data;
        pst_pkg::REG_I_GAIN: i_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mreq.start  = mul_go;
    mreq.mcand  = {{(pst_pkg::MCAND_W - pst_pkg::ERR_W){err_r[pst_pkg::ERR_W-1]}}, err_r};
    mreq.mplier = {2'b00, dt_r};
    mreq.digits = pst_pkg::DT_DIGITS;
    case (state)
      S_MUL_P: begin
        mreq.mplier = {{(pst_pkg::MPLIER_W - pst_pkg::GAIN_W){p_gain[pst_pkg::GAIN_W-1]}},
                       p_gain};
        mreq.digits = pst_pkg::GAIN_DIGITS;
      end
      S_MUL_D: begin
        mreq.mcand  = {{(pst_pkg::MCAND_W - pst_pkg::DATA_W){vel_r[pst_pkg::DATA_W-1]}},
                       vel_r};
        mreq.mplier = {{(pst_pkg::MPLIER_W - pst_pkg::GAIN_W){d_gain[pst_pkg::GAIN_W-1]}},
                       d_gain};
        mreq.digits = pst_pkg::GAIN_DIGITS;
      end
      S_MUL_I: begin
        mreq.mcand  = integral;
        mreq.mplier = {{(pst_pkg::MPLIER_W - pst_pkg::GAIN_W){i_gain[pst_pkg::GAIN_W-1]}},
                       i_gain};
        mreq.digits = pst_pkg::GAIN_DIGITS;
      end
      default: ;
    endcase
  end

  pst_booth_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // err*dt lands in the low 66 product bits; dropping 8 bits floors it
  assign integ_update = (state == S_MUL_T) && mrsp.done;

  pst_integrator u_integ (
    .clk      (clk),
    .rst      (rst),
    .update   (integ_update),
    .inc      (mrsp.product[8 +: pst_pkg::INC_W]),
    .integral (integral)
  );

  always_comb begin
    gprod      = mrsp.product[pst_pkg::PROD_W-1:GP_LSB];
    gprod_x256 = {gprod[GP_LSB + pst_pkg::SUM_W - 9:GP_LSB], 8'h00};
    gprod_ext  = {{(pst_pkg::SUM_W - (pst_pkg::PROD_W - GP_LSB)){gprod[pst_pkg::PROD_W-1]}},
                  gprod};
    // floor(nsum / 2^24) fits 32 bits when bits 75..55 agree
    sat_fits   = (&nsum[pst_pkg::SUM_W-1:55]) | ~(|nsum[pst_pkg::SUM_W-1:55]);
    if (sat_fits) begin
      torque_sat = nsum[55:24];
    end else if (nsum[pst_pkg::SUM_W-1]) begin
      torque_sat = pst_pkg::TORQUE_MIN;
    end else begin
      torque_sat = pst_pkg::TORQUE_MAX;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take) state_next = S_MUL_T;
      S_MUL_T: if (mrsp.done) state_next = S_MUL_P;
      S_MUL_P: if (mrsp.done) state_next = S_MUL_D;
      S_MUL_D: if (mrsp.done) state_next = S_MUL_I;
      S_MUL_I: if (mrsp.done) state_next = S_NEG;
      S_NEG:   state_next = S_SAT;
      S_SAT:   state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mul_go        <= 1'b0;
      previous_time <= '0;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      // kick the multiplier on entry to each multiply state
      mul_go <= (state_next != state) &&
                ((state_next == S_MUL_T) || (state_next == S_MUL_P) ||
                 (state_next == S_MUL_D) || (state_next == S_MUL_I));
      if (in_take) begin
        previous_time <= sample_time;
      end
      if (((state == S_SAT) || (state == S_HOLD)) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      err_r <= {measured_position[31], measured_position}
             - {target_position[31], target_position};
      vel_r <= measured_velocity;
      dt_r  <= sample_time - previous_time;
    end
    case (state)
      S_MUL_P: if (mrsp.done) psum <= gprod_x256;
      S_MUL_D: if (mrsp.done) psum <= psum + gprod_x256;
      S_MUL_I: if (mrsp.done) psum <= psum + gprod_ext;
      S_NEG:   nsum <= -psum;
      default: ;
    endcase
    if (((state == S_SAT) || (state == S_HOLD)) && out_free) begin
      drive_torque <= torque_sat;
    end
  end

endmodule
